FILE: design/sha1_pkg.sv
// SHA-1 engine package: word types, round constants, initial chaining values.
// Used by the schedule unit, the round unit, the top level and the digest checker.
package sha1_pkg;

    typedef logic [31:0] t_word;

    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 80;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam t_word H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // working variables a..e of one round
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_work;

    // control from the sequencer to the schedule unit
    typedef struct packed {
        logic       put;
        logic [7:0] data;
        logic       step;
    } t_sched_ctl;

    function automatic t_word rotl(input t_word x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

endpackage

FILE: design/sha1_if.sv
// Request and digest channels of the SHA-1 engine: valid/ready plus payload.
// Depends on nothing.
interface sha1_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface sha1_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    modport source (output valid, output digest_word, output word_number,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_number,
                  input last_word, output ready);
endinterface

FILE: design/sha1_hash_engine.sv
// SHA-1 hash engine top level: sequencer, chaining value, length counter,
// digest output register. Uses sha1_pkg, sha1_if, sha1_sched and sha1_round.
//
//  channel  | dir | payload                                 | handshake
//  ---------+-----+-----------------------------------------+------------
//  i_req    | in  | kind, data_byte                         | valid/ready
//  o_rsp    | out | digest_word, word_number, last_word     | valid/ready
//
// Data bytes are taken one per cycle while idle; a byte that fills a 64-byte
// block starts a compression: load, 80 rounds on the single shared round unit,
// feed-forward add. End of message feeds zero and length bytes one per cycle
// outside its one or two compressions, then hands out five digest words.
// i_req.ready is high only while the sequencer idles; a digest word waiting
// in the output register does not hold off the next message.
// Synchronous active-low reset; no clearing pass, the engine is ready at once.
module sha1_hash_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha1_req_if.sink      i_req,
    sha1_rsp_if.source    o_rsp
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZERO,
        S_LEN,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state      r_state;
    t_word       r_h [DIGEST_WORDS];
    t_work       r_work;
    logic [6:0]  r_round;
    logic [63:0] r_count;
    logic [63:0] r_len;
    logic        r_fin;      // finishing a message
    logic        r_lendone;  // length bytes are in the last block
    logic [2:0]  r_oidx;
    logic        r_ovalid;
    t_word       r_odata;
    logic [2:0]  r_onum;
    logic        r_olast;

    t_sched_ctl  sched_ctl;
    t_word       sched_w;
    logic [5:0]  sched_pos;
    t_work       round_out;
    logic        req_take;
    logic        pos_wrap;
    logic        out_load;

    assign i_req.ready       = (r_state == S_IDLE);
    assign req_take          = i_req.valid && i_req.ready;
    assign pos_wrap          = (sched_pos == LAST_POS);
    // the output register takes the next digest word when it is empty or
    // its word leaves in this cycle
    assign out_load          = (r_state == S_OUT) && (!r_ovalid || o_rsp.ready);

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.digest_word = r_odata;
    assign o_rsp.word_number = r_onum;
    assign o_rsp.last_word   = r_olast;

    // byte source for the schedule unit: message, pad marker, zeros, length
    always_comb begin
        sched_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                sched_ctl.put  = req_take;
                sched_ctl.data = i_req.kind ? PAD_BYTE : i_req.data_byte;
            end
            S_ZERO: begin
                sched_ctl.put  = (sched_pos != LEN_POS);
                sched_ctl.data = 8'h00;
            end
            S_LEN: begin
                sched_ctl.put  = 1'b1;
                sched_ctl.data = r_len[63:56];
            end
            S_ROUND: begin
                sched_ctl.step = 1'b1;
            end
            default: begin
                sched_ctl = '0;
            end
        endcase
    end

    sha1_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sched_ctl),
        .o_w     (sched_w),
        .o_pos   (sched_pos)
    );

    sha1_round u_round (
        .i_work  (r_work),
        .i_w     (sched_w),
        .i_round (r_round),
        .o_work  (round_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_h[i] <= H_INIT[i];
            end
            r_round   <= '0;
            r_count   <= '0;
            r_fin     <= 1'b0;
            r_lendone <= 1'b0;
            r_oidx    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            // show the next word when S_OUT loads one, else drop the shown
            // word once taken
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        if (!i_req.kind) begin
                            r_count <= r_count + 64'd8;
                            if (pos_wrap) begin
                                r_state <= S_LOAD;
                            end
                        end else begin
                            r_len     <= r_count;
                            r_fin     <= 1'b1;
                            r_lendone <= 1'b0;
                            r_state   <= pos_wrap ? S_LOAD : S_ZERO;
                        end
                    end
                end
                S_ZERO: begin
                    // zero-fill up to the length field, or to a block end
                    if (sched_pos == LEN_POS) begin
                        r_state <= S_LEN;
                    end else if (pos_wrap) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LEN: begin
                    r_len <= {r_len[55:0], 8'h00};
                    if (pos_wrap) begin
                        r_lendone <= 1'b1;
                        r_state   <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_work  <= '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_work  <= round_out;
                    r_round <= r_round + 7'd1;
                    if (r_round == 7'(ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_work.a;
                    r_h[1] <= r_h[1] + r_work.b;
                    r_h[2] <= r_h[2] + r_work.c;
                    r_h[3] <= r_h[3] + r_work.d;
                    r_h[4] <= r_h[4] + r_work.e;
                    r_round <= '0;
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_lendone) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ZERO;
                    end
                end
                S_OUT: begin
                    // shift the digest out of the chaining registers while
                    // the initial values shift in behind it
                    if (out_load) begin
                        r_odata  <= r_h[0];
                        r_onum   <= r_oidx;
                        r_olast  <= (r_oidx == 3'(DIGEST_WORDS - 1));
                        for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                            r_h[i] <= r_h[i + 1];
                        end
                        r_h[DIGEST_WORDS - 1] <= H_INIT[r_oidx];
                        if (r_oidx == 3'(DIGEST_WORDS - 1)) begin
                            r_fin     <= 1'b0;
                            r_lendone <= 1'b0;
                            r_count   <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // the last round hands over to the feed-forward add
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == 7'(ROUNDS - 1)) |=> (r_state == S_ADD))
        else $error("round counter did not end compression");

    // the final block closes exactly on a block boundary
    a_final_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && r_fin && r_lendone) |-> (sched_pos == 6'd0))
        else $error("final block not aligned");

    // no request is taken while a message is being finished
    a_no_take_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !r_fin)
        else $error("request taken during finalization");

    // the last-word flag marks the fifth digest word only
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.last_word) |-> (o_rsp.word_number == 3'(DIGEST_WORDS - 1)))
        else $error("last_word on wrong digest word");

endmodule

FILE: design/sha1_sched.sv
// SHA-1 message schedule: packs bytes into words and expands W[16..79].
// Sixteen-word shift line whose head is W[t]; depends on sha1_pkg.
module sha1_sched (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha1_pkg::t_sched_ctl i_ctl,
    output sha1_pkg::t_word     o_w,
    output logic [5:0]          o_pos
);
    import sha1_pkg::*;

    logic [5:0]  r_pos;
    logic [23:0] r_acc;
    t_word       r_w [BLOCK_WORDS];
    t_word       w_next;

    assign w_next = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    assign o_w    = r_w[0];
    assign o_pos  = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_ctl.put) begin
            r_pos <= r_pos + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.put) begin
            if (r_pos[1:0] == 2'd3) begin
                for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                    r_w[k] <= r_w[k + 1];
                end
                r_w[BLOCK_WORDS - 1] <= {r_acc, i_ctl.data};
            end else begin
                r_acc <= {r_acc[15:0], i_ctl.data};
            end
        end else if (i_ctl.step) begin
            for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                r_w[k] <= r_w[k + 1];
            end
            r_w[BLOCK_WORDS - 1] <= w_next;
        end
    end

endmodule

FILE: design/sha1_round.sv
// One SHA-1 round: selects f and K by round number and forms the next a..e.
// Pure logic, reused for all 80 rounds; depends on sha1_pkg.
module sha1_round (
    input  sha1_pkg::t_work i_work,
    input  sha1_pkg::t_word i_w,
    input  logic [6:0]      i_round,
    output sha1_pkg::t_work o_work
);
    import sha1_pkg::*;

    t_word f;
    t_word k;

    always_comb begin
        if (i_round < 7'd20) begin
            f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k = K_0;
        end else if (i_round < 7'd40) begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = K_1;
        end else if (i_round < 7'd60) begin
            f = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k = K_2;
        end else begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = K_3;
        end
    end

    always_comb begin
        o_work.a = rotl(i_work.a, 5) + f + i_work.e + k + i_w;
        o_work.b = i_work.a;
        o_work.c = rotl(i_work.b, 30);
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule

FILE: dv/sha1_tb_pkg.sv
`timescale 1ns / 100ps
// Shared testbench types for the SHA-1 engine: request kinds and the digest word record.
// Depends on nothing; used by the scoreboard and the testbench top.
package sha1_tb_pkg;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_digest_item;

endpackage

FILE: dv/sha1_digest_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the SHA-1 engine: follows accepted requests, predicts digest words, checks them.
// Depends on sha1_pkg, sha1_tb_pkg and the channel interfaces of sha1_if.
module sha1_digest_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sha1_req_if  i_req,
    sha1_rsp_if  i_rsp,
    output int   o_err_count,
    output int   o_pending
);
    import sha1_pkg::*;
    import sha1_tb_pkg::*;

    t_word        chain_words [DIGEST_WORDS];
    t_word        block_buf [BLOCK_WORDS];
    logic [5:0]   fill_pos;
    logic [63:0]  bit_total;
    logic [63:0]  msg_bits;
    t_digest_item digest_expect_q [$];
    t_digest_item want;
    t_digest_item got;

    // pack one byte big-endian; a full block runs the 80 rounds
    function automatic void absorb_byte(input logic [7:0] din);
        t_word sched [ROUNDS];
        t_word a, b, c, d, e, f, k, t;
        if (fill_pos[1:0] == 2'd0)
            block_buf[fill_pos[5:2]] = {din, 24'h0};
        else
            block_buf[fill_pos[5:2]] = block_buf[fill_pos[5:2]]
                                     | (t_word'(din) << (8 * (3 - fill_pos[1:0])));
        fill_pos = fill_pos + 6'd1;
        if (fill_pos != 6'd0)
            return;
        for (int i = 0; i < ROUNDS; i++) begin
            if (i < BLOCK_WORDS) begin
                sched[i] = block_buf[i];
            end else begin
                t = sched[i - 3] ^ sched[i - 8] ^ sched[i - 14] ^ sched[i - 16];
                sched[i] = {t[30:0], t[31]};
            end
        end
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (int r = 0; r < ROUNDS; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end else begin
                f = b ^ c ^ d;
                k = K_3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + sched[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_words[0] = chain_words[0] + a;
        chain_words[1] = chain_words[1] + b;
        chain_words[2] = chain_words[2] + c;
        chain_words[3] = chain_words[3] + d;
        chain_words[4] = chain_words[4] + e;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chain_words = H_INIT;
            foreach (block_buf[i])
                block_buf[i] = '0;
            fill_pos    = '0;
            bit_total   = '0;
            digest_expect_q.delete();
            o_err_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.digest_word, i_rsp.word_number, i_rsp.last_word};
                if (digest_expect_q.size() == 0) begin
                    $display("%0t: unexpected digest word: expected none, %s %h word %0d last %b",
                             $time, "got", got.digest_word, got.word_number,
                             got.last_word);
                    o_err_count++;
                end else begin
                    want = digest_expect_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: digest mismatch: expected %h word %0d last %b,",
                                 $time, want.digest_word, want.word_number,
                                 want.last_word,
                                 " got %h word %0d last %b",
                                 got.digest_word, got.word_number, got.last_word);
                        o_err_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.kind == KIND_DATA) begin
                    absorb_byte(i_req.data_byte);
                    bit_total = bit_total + 64'd8;
                end else begin
                    // pad byte, zeros to the length slot, then the big-endian bit count
                    msg_bits = bit_total;
                    absorb_byte(PAD_BYTE);
                    while (fill_pos != LEN_POS)
                        absorb_byte(8'h00);
                    for (int i = 7; i >= 0; i--)
                        absorb_byte(msg_bits[8 * i +: 8]);
                    for (int i = 0; i < DIGEST_WORDS; i++) begin
                        want = '{chain_words[i], 3'(i), (i == DIGEST_WORDS - 1)};
                        digest_expect_q.insert(digest_expect_q.size(), want);
                    end
                    chain_words = H_INIT;
                    bit_total   = '0;
                end
            end
        end
        o_pending = digest_expect_q.size();
    end

endmodule

FILE: dv/tb_sha1_hash_engine.sv
`timescale 1ns / 100ps
// Testbench top for the SHA-1 engine: clock, reset, request and response pacing, verdict.
// Depends on sha1_pkg, sha1_tb_pkg, sha1_if, sha1_digest_checker and the engine itself.
module tb_sha1_hash_engine;
    import sha1_tb_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    int   err_count;
    int   pending;

    // pacing switches, flipped per message to get busy and quiet stretches
    bit   req_gaps_on  = 1'b1;
    bit   rsp_stall_on = 1'b1;
    int   items_sent   = 0;

    sha1_req_if req_ch ();
    sha1_rsp_if rsp_ch ();

    sha1_hash_engine DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    sha1_digest_checker digest_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always #6 clk = ~clk;

    // Idle length: mostly none, often a few cycles, now and then a long pause.
    function automatic int idle_cycles(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one request at the falling edge and hold it until the engine takes it.
    // With no gap, valid stays high and only the payload moves on.
    task automatic put_request(input logic kind, input logic [7:0] data);
        int gap;
        gap = idle_cycles(req_gaps_on);
        @(negedge clk);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.kind      = kind;
        req_ch.data_byte = data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    // Send a message of random bytes, then the end-of-message request with a junk byte.
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            put_request(KIND_DATA, 8'($urandom_range(0, 255)));
        put_request(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    // Response side: drop ready for random stretches, keep it high otherwise.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end else begin
                stall_left = idle_cycles(rsp_stall_on);
                if (stall_left > 0) begin
                    rsp_ch.ready = 1'b0;
                    stall_left--;
                end else begin
                    rsp_ch.ready = 1'b1;
                end
            end
        end
    end

    initial begin
        int boundary_lens [8];
        int msg_count;
        int len;
        int r;

        boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        msg_count     = 0;

        req_ch.valid     = 1'b0;
        req_ch.kind      = KIND_DATA;
        req_ch.data_byte = 8'h00;
        rst_n            = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty message, empty again with an all-ones ignored byte,
        // the classic "abc" vector, byte extremes, a lone 0xFF.
        put_request(KIND_END, 8'h00);
        put_request(KIND_END, 8'hFF);
        put_request(KIND_DATA, 8'h61);
        put_request(KIND_DATA, 8'h62);
        put_request(KIND_DATA, 8'h63);
        put_request(KIND_END, 8'h00);
        put_request(KIND_DATA, 8'h00);
        put_request(KIND_DATA, 8'hFF);
        put_request(KIND_DATA, 8'h80);
        put_request(KIND_DATA, 8'h7F);
        put_request(KIND_END, 8'h55);
        put_request(KIND_DATA, 8'hFF);
        put_request(KIND_END, 8'hAA);

        // Random messages: mostly short, a good share sitting on the padding
        // boundaries (length slot fits, just overflows, exact block fill),
        // the rest anywhere up to a couple of blocks.
        while (items_sent < 270 || msg_count < 5) begin
            req_gaps_on  = ($urandom_range(0, 3) != 0);
            rsp_stall_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 60)
                len = $urandom_range(0, 12);
            else if (r < 85)
                len = boundary_lens[$urandom_range(0, 7)];
            else
                len = $urandom_range(0, 130);
            send_message(len);
            msg_count++;
            // hold off new requests once until every digest word has drained
            if (msg_count == 4) begin
                @(negedge clk);
                req_ch.valid = 1'b0;
                wait (pending == 0);
            end
        end

        @(negedge clk);
        req_ch.valid = 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (100) @(posedge clk);

        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
